@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the pulse generator RTL.
// Included by modules that carry concurrent checks; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OMPG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define OMPG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ompg_pkg.sv @@
// Shared types and constants for the step/direction pulse generator.
// No dependencies; imported by ompg_ctrl, ompg_dpath and the top level.
`default_nettype none

package ompg_pkg;

    localparam int unsigned TICK_RATE_HZ_DEF = 1000000;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_STEP_LIMIT    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INIT_DELAY    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MICROSTEP_LOG = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_INCR    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_SPEED     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_SPEED     = 3'd5;

    localparam logic [15:0] RST_STEP_LIMIT = 16'd0;
    localparam logic [15:0] RST_INIT_DELAY = 16'd12500;
    localparam logic [2:0]  RST_MSTEP_LOG  = 3'd4;
    localparam logic [7:0]  RST_SPEED_INCR = 8'd1;
    localparam logic [15:0] RST_MIN_SPEED  = 16'd50;
    localparam logic [15:0] RST_MAX_SPEED  = 16'd400;
    localparam logic [15:0] RST_SPEED      = 16'd80;
    localparam logic [2:0]  MAX_MSTEP_LOG  = 3'd4;
    localparam logic [15:0] PERIOD_SAT     = 16'hFFFF;

    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_ADJUST = 1'b1;

    // step_pulse, direction, three mode pins, speed, period
    localparam int unsigned OUT_W   = 37;
    localparam int unsigned TDATA_W = 40;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } ompg_state_t;

    typedef struct packed {
        logic accept;
        logic tick;
        logic adjust;
        logic div_step;
        logic load_out;
    } ompg_cmd_t;

    typedef struct packed {
        logic div_last;
    } ompg_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/ompg_ctrl.sv @@
// Sequencer for the pulse generator: accepts items, runs the divider, emits results.
// Depends on ompg_pkg and assert_macros.svh; drives ompg_dpath through a command struct.
`default_nettype none
`include "assert_macros.svh"

module ompg_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic                  action,
    input  wire logic                  button_held,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output ompg_pkg::ompg_cmd_t        cmd,
    input  wire ompg_pkg::ompg_status_t status
);
    import ompg_pkg::*;

    ompg_state_t state_reg;
    ompg_state_t state_next;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    if (action == ACT_TICK)
                    begin
                        cmd.tick   = 1'b1;
                        state_next = S_EMIT;
                    end
                    else if (button_held)
                    begin
                        cmd.adjust = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // load the output register once the previous result has left
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    `OMPG_ASSERT_NXT(a_div_ends_in_emit, clk, rst_n,
        (state_reg == S_DIV) && status.div_last, state_reg == S_EMIT,
        "divider finish did not lead to result emission")
    `OMPG_ASSERT_NXT(a_emit_sets_valid, clk, rst_n,
        cmd.load_out, m_tvalid_reg && (state_reg == S_IDLE),
        "loaded result not presented")
    `OMPG_ASSERT_IMP(a_no_accept_while_busy, clk, rst_n,
        (state_reg == S_DIV) || (state_reg == S_EMIT), !cmd.accept,
        "item accepted while a previous item is in flight")

endmodule

`default_nettype wire

@@ hw/rtl/ompg_dpath.sv @@
// Datapath: config registers, step timer and counters, speed update,
// restoring divider for the period and the result register. Depends on ompg_pkg.
`default_nettype none
`include "assert_macros.svh"

module ompg_dpath #(
    parameter int unsigned TICK_RATE_HZ = ompg_pkg::TICK_RATE_HZ_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    input  wire logic [ompg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [ompg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire ompg_pkg::ompg_cmd_t             cmd,
    output ompg_pkg::ompg_status_t               status,
    output logic [ompg_pkg::OUT_W-1:0]           result
);
    import ompg_pkg::*;

    localparam int unsigned DIV_W = $clog2(TICK_RATE_HZ + 1);
    localparam int unsigned CNT_W = $clog2(DIV_W + 1);
    localparam int unsigned QX_W  = (DIV_W > 17) ? DIV_W : 17;
    localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(TICK_RATE_HZ);

    // configuration
    logic [15:0] step_limit_reg;
    logic [15:0] init_delay_reg;
    logic [2:0]  mstep_log_reg;
    logic [7:0]  speed_incr_reg;
    logic [15:0] min_speed_reg;
    logic [15:0] max_speed_reg;

    // motion state
    logic [15:0] timer_reg,  timer_next;
    logic [4:0]  mstep_reg,  mstep_next;
    logic [15:0] fstep_reg,  fstep_next;
    logic        dir_reg,    dir_next;
    logic [15:0] speed_reg,  speed_next;
    logic [15:0] delay_reg,  delay_next;
    logic        pulse_reg,  pulse_next;

    // divider
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;

    logic [OUT_W-1:0] out_reg;

    logic [2:0]  lg;
    logic [4:0]  mstep_inc;
    logic [15:0] fstep_inc;
    logic [16:0] speed_sum;
    logic [16:0] trial;
    logic        trial_ge;
    logic [DIV_W-1:0] quo_step;
    logic [QX_W-1:0]  quo_ext;
    logic             quo_sat;
    logic        mode1, mode2, mode3;

    assign lg = (mstep_log_reg > MAX_MSTEP_LOG) ? MAX_MSTEP_LOG : mstep_log_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_limit_reg <= RST_STEP_LIMIT;
            init_delay_reg <= RST_INIT_DELAY;
            mstep_log_reg  <= RST_MSTEP_LOG;
            speed_incr_reg <= RST_SPEED_INCR;
            min_speed_reg  <= RST_MIN_SPEED;
            max_speed_reg  <= RST_MAX_SPEED;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_addr)
                REG_STEP_LIMIT:    step_limit_reg <= cfg_data;
                REG_INIT_DELAY:    init_delay_reg <= cfg_data;
                REG_MICROSTEP_LOG: mstep_log_reg  <= cfg_data[2:0];
                REG_SPEED_INCR:    speed_incr_reg <= cfg_data[7:0];
                REG_MIN_SPEED:     min_speed_reg  <= cfg_data;
                REG_MAX_SPEED:     max_speed_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // one restoring-division step: shift in the next dividend bit, try subtract
    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_ge = trial >= {1'b0, speed_reg};
    assign quo_step = {quo_reg[DIV_W-2:0], trial_ge};
    assign quo_ext  = QX_W'(quo_step);
    assign quo_sat  = |quo_ext[QX_W-1:16];

    assign mstep_inc = mstep_reg + 5'd1;
    assign fstep_inc = fstep_reg + 16'd1;
    assign speed_sum = {1'b0, speed_reg} + {9'd0, speed_incr_reg};

    always_comb
    begin
        timer_next = timer_reg;
        mstep_next = mstep_reg;
        fstep_next = fstep_reg;
        dir_next   = dir_reg;
        speed_next = speed_reg;
        delay_next = delay_reg;
        pulse_next = pulse_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;

        if (cmd.accept)
        begin
            pulse_next = 1'b0;
        end

        if (cmd.tick)
        begin
            if (timer_reg == 16'd0)
            begin
                pulse_next = 1'b1;
                timer_next = delay_reg >> lg;
                mstep_next = mstep_inc;
                fstep_next = fstep_reg;
                if (mstep_inc >= (5'd1 << lg))
                begin
                    mstep_next = 5'd0;
                    fstep_next = fstep_inc;
                end
                // reverse once the sweep passes its limit
                if (fstep_next > step_limit_reg)
                begin
                    dir_next   = ~dir_reg;
                    fstep_next = 16'd0;
                end
            end
            else
            begin
                timer_next = timer_reg - 16'd1;
            end
        end

        if (cmd.adjust)
        begin
            speed_next = (speed_sum > {1'b0, max_speed_reg}) ? min_speed_reg
                                                              : speed_sum[15:0];
            cnt_next   = CNT_W'(DIV_W);
            rem_next   = 16'd0;
            quo_next   = DIVIDEND;
        end

        if (cmd.div_step)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            rem_next = trial_ge ? 16'(trial - {1'b0, speed_reg}) : trial[15:0];
            quo_next = quo_step;
            if (status.div_last)
            begin
                delay_next = ((speed_reg == 16'd0) || quo_sat) ? PERIOD_SAT
                                                               : quo_ext[15:0];
            end
        end

        if (cfg_valid && (cfg_addr == REG_INIT_DELAY))
        begin
            delay_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= 16'd0;
            mstep_reg <= 5'd0;
            fstep_reg <= 16'd0;
            dir_reg   <= 1'b1;
            speed_reg <= RST_SPEED;
            delay_reg <= RST_INIT_DELAY;
            pulse_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            timer_reg <= timer_next;
            mstep_reg <= mstep_next;
            fstep_reg <= fstep_next;
            dir_reg   <= dir_next;
            speed_reg <= speed_next;
            delay_reg <= delay_next;
            pulse_reg <= pulse_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.load_out)
        begin
            out_reg <= {delay_reg, speed_reg, mode3, mode2, mode1, dir_reg, pulse_reg};
        end
    end

    assign mode1 = (lg == 3'd1) || (lg == 3'd3) || (lg == 3'd4);
    assign mode2 = (lg == 3'd2) || (lg == 3'd3) || (lg == 3'd4);
    assign mode3 = (lg == 3'd4);

    assign status.div_last = (cnt_reg == CNT_W'(1));
    assign result          = out_reg;

    `OMPG_ASSERT_NXT(a_dir_only_on_tick, clk, rst_n,
        !cmd.tick, $stable(dir_reg),
        "direction changed without a tick")
    `OMPG_ASSERT_NXT(a_speed_only_on_adjust, clk, rst_n,
        !cmd.adjust, $stable(speed_reg),
        "speed changed without an adjust item")
    `OMPG_ASSERT_IMP(a_mstep_in_range, clk, rst_n,
        1'b1, mstep_reg < 5'd16,
        "microstep count out of range")

endmodule

`default_nettype wire

@@ hw/rtl/oscillating_microstep_pulse_generator.sv @@
// Step/direction pulse generator for a microstepping driver.
//
// Input channel s_*: one item per tick (s_tuser action = 0) or per speed
// adjust event (action = 1, s_tdata bit 0 = button held). Output channel m_*:
// one result per input item with the step pulse, direction, mode pins, speed
// and period after that item. Config channel cfg_*: register index and data,
// always ready; write only while no item is in flight.
//
// Flow: a tick or an adjust without the button goes from S_IDLE to S_EMIT,
// where its result is loaded into the output register. An adjust with the
// button held first runs a restoring divider in S_DIV, one quotient bit per
// cycle, before S_EMIT; no new item is accepted while one is in flight.
// The next item is accepted in the cycle after the result is loaded.
// If the receiver stalls, the result waits in the output register and one
// more item is accepted and processed; it then holds until the register
// frees. Reset restores the config, motion, divider count and control
// registers to their defaults, no clearing pass; rem, quo and out are not.
// Depends on ompg_pkg, ompg_ctrl and ompg_dpath.
`default_nettype none

module oscillating_microstep_pulse_generator #(
    parameter int unsigned TICK_RATE_HZ = ompg_pkg::TICK_RATE_HZ_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [0] button_held
    input  wire logic                            s_tuser,   // [0] action
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [0] step_pulse, [1] direction, [2] mode_pin1, [3] mode_pin2,
    // [4] mode_pin3, [20:5] current_speed, [36:21] period_value
    output logic [ompg_pkg::TDATA_W-1:0]         m_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ompg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [ompg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ompg_pkg::*;

    ompg_cmd_t        cmd;
    ompg_status_t     status;
    logic [OUT_W-1:0] result;

    ompg_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .action      (s_tuser),
        .button_held (s_tdata[0]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .status      (status)
    );

    ompg_dpath #(
        .TICK_RATE_HZ (TICK_RATE_HZ)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    assign cfg_ready = 1'b1;
    assign m_tdata   = {(TDATA_W - OUT_W)'(0), result};

endmodule

`default_nettype wire
